### src/ohs_pkg.sv
// ----------------------------------------------------------------------------
// ohs_pkg
// Shared types, constants and helpers of the overlap histogram block.
// ----------------------------------------------------------------------------
package ohs_pkg;

  localparam int NUM_BINS    = 64;
  localparam int COUNT_WIDTH = 32;

  localparam int EVEN_BINS = (NUM_BINS / 2) * 2;
  localparam int HALF_BINS = EVEN_BINS / 2;
  localparam int BIN_W     = $clog2(NUM_BINS);
  localparam int PAIR_W    = (HALF_BINS > 1) ? $clog2(HALF_BINS) : 1;
  localparam int MUL_W     = COUNT_WIDTH + 16;

  localparam logic [15:0] TOL_RESET = 16'd3277;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_addr_t;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } ohs_req_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_SYM       = 2'd1,
    STAT_ASYM      = 2'd2,
    STAT_LOW_STATS = 2'd3
  } ohs_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_CHK_RDA,
    ST_CHK_RDB,
    ST_CHK_MUL,
    ST_CHK_CMP,
    ST_DONE
  } ohs_state_t;

  // Access request from the sequencer to the bin store.
  typedef struct packed {
    logic      rd_en;
    bin_addr_t rd_addr;
    logic      wr_en;
    bin_addr_t wr_addr;
    count_t    wr_data;
  } ohs_mem_req_t;

  function automatic count_t sat_inc(input count_t c);
    count_t r;
    r = (c == '1) ? c : c + 1'b1;
    return r;
  endfunction

  // Truncates or zero-extends a count to the 32-bit result fields.
  function automatic logic [31:0] to_out32(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[31:0];
  endfunction

endpackage

### src/ohs_bin_store.sv
// ----------------------------------------------------------------------------
// ohs_bin_store
// Bin count memory with one read and one write port and a valid bit per
// entry; an entry not written since reset reads as zero.
// ----------------------------------------------------------------------------
module ohs_bin_store
  import ohs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  ohs_mem_req_t mem_req,
  output count_t       rd_data
);

  count_t              bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0] valid_r;
  count_t              rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      bin_mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_data_r <= bin_mem[mem_req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_req.wr_en) begin
        valid_r[mem_req.wr_addr] <= 1'b1;
      end
      if (mem_req.rd_en) begin
        rd_vld_r <= valid_r[mem_req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

### src/overlap_histogram_symmetry.sv
// ----------------------------------------------------------------------------
// overlap_histogram_symmetry
// Histogram of overlap values in [-1,1] with push, symmetry check and read.
// ----------------------------------------------------------------------------
// One request is handled at a time and every request gives one result beat.
// A push reads, increments and writes back one bin, a read fetches one bin
// and an unused request type goes straight to its result beat.
// A symmetry check walks k mirrored pairs before it stops (at most
// NUM_BINS/2): each pair costs two reads of the single read port of the bin
// store and one pass through the shared multiply and compare unit. Counts
// are cleared at reset by per-entry valid bits, so no clearing pass is
// needed.
module overlap_histogram_symmetry
  import ohs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: sample [16:0], bin_index [22:17], zero [23]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // in_tuser: req_type [1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: bin_count [31:0], running_total [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  // out_tuser: status [1:0]
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ohs_state_t   state_r, state_nxt;
  ohs_mem_req_t mem_req;
  count_t       rd_data;

  ohs_req_t     in_req;
  ohs_req_t     req_r;
  logic [15:0]  tol_r;
  bin_addr_t    bin_r;
  bin_addr_t    push_bin;
  bin_addr_t    read_addr;
  logic         read_ok;
  logic         read_ok_r;
  logic [PAIR_W-1:0] pair_r;
  bin_addr_t    pair_addr;
  bin_addr_t    mirror_addr;
  logic         last_pair;

  count_t       a_r;
  count_t       diff_r;
  logic         b_zero_r;
  logic [MUL_W-1:0] prod_r;
  logic         asym;

  count_t       cnt_r;
  ohs_status_t  status_r;
  count_t       total_r;

  logic         out_tvalid_r;
  logic [1:0]   out_status_r;
  logic [31:0]  out_count_r;
  logic [31:0]  out_total_r;

  logic signed [16:0] sample;
  logic signed [17:0] v_clamp;
  logic [31:0]  pos;
  logic [31:0]  bin_full;
  logic [31:0]  idx_full;
  logic [31:0]  mirror_full;

  assign in_req    = ohs_req_t'(in_tuser);
  assign sample    = $signed(in_tdata[16:0]);
  assign cfg_ready = 1'b1;

  // Binning: clamp to [-1,1], shift to [0,2], scale by half the bins.
  always_comb begin
    v_clamp = 18'(sample);
    if (v_clamp < -18'sd32768) begin
      v_clamp = -18'sd32768;
    end else if (v_clamp > 18'sd32768) begin
      v_clamp = 18'sd32768;
    end
    pos      = 32'(v_clamp + 18'sd32768);
    bin_full = (pos * 32'(HALF_BINS)) >> 15;
    if (bin_full > 32'(EVEN_BINS - 1)) begin
      bin_full = 32'(EVEN_BINS - 1);
    end
    push_bin = bin_full[BIN_W-1:0];
  end

  assign idx_full    = 32'(in_tdata[22:17]);
  assign read_ok     = idx_full < 32'(EVEN_BINS);
  assign read_addr   = idx_full[BIN_W-1:0];
  assign pair_addr   = BIN_W'(pair_r);
  assign mirror_full = 32'(EVEN_BINS - 1) - 32'(pair_r);
  assign mirror_addr = mirror_full[BIN_W-1:0];
  assign last_pair   = 32'(pair_r) == 32'(HALF_BINS - 1);
  assign asym        = {diff_r, 16'b0} > prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_tready       = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = pair_addr;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = bin_r;
    mem_req.wr_data = sat_inc(rd_data);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_req)
            REQ_PUSH: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = push_bin;
              state_nxt       = ST_PUSH;
            end
            REQ_CHECK: state_nxt = ST_CHK_RDA;
            REQ_READ: begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = read_addr;
              state_nxt       = ST_READ;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PUSH: begin
        mem_req.wr_en = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_READ: state_nxt = ST_DONE;
      ST_CHK_RDA: begin
        mem_req.rd_en = 1'b1;
        state_nxt     = ST_CHK_RDB;
      end
      ST_CHK_RDB: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = mirror_addr;
        state_nxt       = ST_CHK_MUL;
      end
      ST_CHK_MUL: state_nxt = ST_CHK_CMP;
      ST_CHK_CMP: begin
        if (b_zero_r || asym || last_pair) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHK_RDA;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  ohs_bin_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // Datapath and the shared multiply and compare unit.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_r     <= in_req;
          bin_r     <= push_bin;
          read_ok_r <= read_ok;
          cnt_r     <= '0;
          status_r  <= STAT_DONE;
        end
      end
      ST_PUSH: cnt_r <= sat_inc(rd_data);
      ST_READ: cnt_r <= read_ok_r ? rd_data : '0;
      ST_CHK_RDB: a_r <= rd_data;
      ST_CHK_MUL: begin
        diff_r   <= (a_r > rd_data) ? a_r - rd_data : rd_data - a_r;
        prod_r   <= MUL_W'(tol_r) * MUL_W'(rd_data);
        b_zero_r <= rd_data == '0;
      end
      ST_CHK_CMP: begin
        if (b_zero_r) begin
          status_r <= STAT_LOW_STATS;
        end else if (asym) begin
          status_r <= STAT_ASYM;
        end else begin
          status_r <= STAT_SYM;
        end
      end
      default: ;
    endcase
    if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_status_r <= status_r;
      out_count_r  <= to_out32(cnt_r);
      out_total_r  <= to_out32(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r        <= TOL_RESET;
      total_r      <= '0;
      pair_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
      if (state_r == ST_PUSH) begin
        total_r <= sat_inc(total_r);
      end
      if (state_r == ST_IDLE) begin
        pair_r <= '0;
      end else if (state_r == ST_CHK_CMP && !(b_zero_r || asym || last_pair)) begin
        pair_r <= pair_r + 1'b1;
      end
      if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_total_r, out_count_r};
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  // A push beat raises the total by one, or leaves it at saturation.
  a_push_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_req == REQ_PUSH) |-> ##2
      (total_r == sat_inc($past(total_r, 2))))
    else $error("total not incremented after push");

  // A finished result is held back while the previous beat is still waiting.
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_tvalid_r && !out_tready) |=> (state_r == ST_DONE))
    else $error("result overwritten before it was taken");

  // A check never completes with the plain done status.
  a_check_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && req_r == REQ_CHECK) |-> (status_r != STAT_DONE))
    else $error("check finished without a verdict");

  // The pair walk stays within the lower half of the bins.
  a_pair_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(pair_r) < 32'(HALF_BINS)))
    else $error("pair index beyond half the bins");
`endif

endmodule
